[rtl/core/deque_with_value_removal_assert.svh]
// ----------------------------------------------------------------------------
// Deque assertion macros
// Concurrent assertion shorthands that are clocked on clk_i and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_VALUE_REMOVAL_ASSERT_SVH
`define DEQUE_WITH_VALUE_REMOVAL_ASSERT_SVH

`ifndef SYNTHESIS
`define DQVR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("deque assertion failed");
`define DQVR_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("deque forbidden condition seen");
`else
`define DQVR_ASSERT(name, prop)
`define DQVR_ASSERT_NEVER(name, cond)
`endif

`endif

[rtl/core/dqvr_pkg.sv]
// ----------------------------------------------------------------------------
// Deque package
// Command and status codes, cell operations and the control bundle that
// is broadcast to every cell of the row.
// ----------------------------------------------------------------------------
package dqvr_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IN_DATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE     = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_NOP        = 3'd0,
    CELL_PUSH_BACK  = 3'd1,
    CELL_PUSH_FRONT = 3'd2,
    CELL_POP_FRONT  = 3'd3,
    CELL_POP_BACK   = 3'd4,
    CELL_MATCH      = 3'd5,
    CELL_REMOVE     = 3'd6,
    CELL_CLEAR      = 3'd7
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [VALUE_W-1:0] key;
  } cell_ctrl_t;

endpackage

[rtl/core/dqvr_cell.sv]
// ----------------------------------------------------------------------------
// Deque cell
// One entry of the queue: a value, a valid bit and a match flag. It loads
// from its left or right neighbor to shift the row, and compares its value
// with the broadcast key.
// ----------------------------------------------------------------------------
module dqvr_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dqvr_pkg::cell_ctrl_t         ctrl_i,
  input  logic                         shift_i,
  input  logic [dqvr_pkg::VALUE_W-1:0] left_value_i,
  input  logic                         left_valid_i,
  input  logic [dqvr_pkg::VALUE_W-1:0] right_value_i,
  input  logic                         right_valid_i,
  output logic [dqvr_pkg::VALUE_W-1:0] value_o,
  output logic                         valid_o,
  output logic                         match_o,
  output logic                         last_o
);
  import dqvr_pkg::*;

  logic [VALUE_W-1:0] value_d, value_q;
  logic               valid_d, valid_q;
  logic               match_d, match_q;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    match_d = match_q;
    unique case (ctrl_i.op)
      CELL_NOP: ;
      CELL_PUSH_BACK: begin
        if (!valid_q && left_valid_i) begin
          value_d = ctrl_i.key;
          valid_d = 1'b1;
        end
      end
      CELL_PUSH_FRONT: begin
        value_d = left_value_i;
        valid_d = left_valid_i;
      end
      CELL_POP_FRONT: begin
        value_d = right_value_i;
        valid_d = right_valid_i;
      end
      CELL_POP_BACK: begin
        if (valid_q && !right_valid_i) begin
          valid_d = 1'b0;
        end
      end
      CELL_MATCH: begin
        match_d = valid_q && (value_q == ctrl_i.key);
      end
      CELL_REMOVE: begin
        if (shift_i) begin
          value_d = right_value_i;
          valid_d = right_valid_i;
        end
      end
      CELL_CLEAR: begin
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;
  assign match_o = match_q;
  assign last_o  = valid_q & ~right_valid_i;

endmodule

[rtl/core/deque_with_value_removal.sv]
// ----------------------------------------------------------------------------
// Deque with value removal
// Bounded double-ended queue built as a row of shifting cells, with push and
// pop at both ends, removal of the first matching value, and clear.
// ----------------------------------------------------------------------------
// Each command accepted on the slave side gives exactly one result transfer
// on the master side. Push, pop and clear first update the cell row, and
// the result is then formed from the new contents. Remove first has every
// cell register its compare with the key, then closes the row up behind the
// first match before the result is formed. The block takes one command
// at a time, and the result register lets the next command in while a
// finished result still waits to be taken.
module deque_with_value_removal #(
  parameter  int unsigned DEPTH    = 16,
  localparam int unsigned CountW   = $clog2(DEPTH + 1),
  localparam int unsigned OutRawW  = 3 * dqvr_pkg::VALUE_W + dqvr_pkg::STATUS_W + CountW,
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command [2:0], value [34:3]
  input  logic [dqvr_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // popped_value, status, entry_count, head_value, tail_value
  output logic [OutDataW-1:0]            m_axis_tdata_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i
);
  import dqvr_pkg::*;

  `include "deque_with_value_removal_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_REMOVE = 3'b010,
    S_REPORT = 3'b100
  } state_e;

  state_e              state_d, state_q;
  logic [CountW-1:0]   count_d, count_q;
  logic [VALUE_W-1:0]  popped_d, popped_q;
  status_e             status_d, status_q;
  logic                out_valid_d, out_valid_q;
  logic [OutDataW-1:0] out_data_d, out_data_q;

  cell_ctrl_t          ctrl;
  logic [VALUE_W-1:0]  cell_value [DEPTH];
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    cell_match;
  logic [DEPTH-1:0]    cell_last;
  logic [DEPTH-1:0]    shift_sel;
  logic [VALUE_W-1:0]  tail_sel;
  logic [VALUE_W-1:0]  head_sel;
  logic                in_fire;
  logic                q_full;
  logic                q_empty;
  logic [CMD_W-1:0]    in_cmd;
  logic [VALUE_W-1:0]  in_value;

  assign in_cmd   = s_axis_tdata_i[CMD_W-1:0];
  assign in_value = s_axis_tdata_i[CMD_W+VALUE_W-1:CMD_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign q_full          = cell_valid[DEPTH-1];
  assign q_empty         = !cell_valid[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] left_value, right_value;
    logic               left_valid, right_valid;

    if (i == 0) begin : g_first
      assign left_value = ctrl.key;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    dqvr_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .shift_i       (shift_sel[i]),
      .left_value_i  (left_value),
      .left_valid_i  (left_valid),
      .right_value_i (right_value),
      .right_valid_i (right_valid),
      .value_o       (cell_value[i]),
      .valid_o       (cell_valid[i]),
      .match_o       (cell_match[i]),
      .last_o        (cell_last[i])
    );
  end

  // A cell closes up when it holds or follows the first match.
  always_comb begin
    shift_sel = cell_match;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      shift_sel = shift_sel | (shift_sel << s);
    end
  end

  always_comb begin
    tail_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_sel = tail_sel | (cell_value[i] & {VALUE_W{cell_last[i]}});
    end
  end

  assign head_sel = cell_valid[0] ? cell_value[0] : '0;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    popped_d    = popped_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ctrl.op     = CELL_NOP;
    ctrl.key    = in_value;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          popped_d = '0;
          status_d = ST_OK;
          state_d  = S_REPORT;
          unique case (cmd_e'(in_cmd))
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
              if (q_full) begin
                status_d = ST_FULL;
              end else begin
                ctrl.op = (cmd_e'(in_cmd) == CMD_PUSH_BACK) ? CELL_PUSH_BACK
                                                             : CELL_PUSH_FRONT;
                count_d = count_q + CountW'(1);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (q_empty) begin
                status_d = ST_EMPTY;
              end else begin
                if (cmd_e'(in_cmd) == CMD_POP_FRONT) begin
                  ctrl.op  = CELL_POP_FRONT;
                  popped_d = cell_value[0];
                end else begin
                  ctrl.op  = CELL_POP_BACK;
                  popped_d = tail_sel;
                end
                count_d = count_q - CountW'(1);
              end
            end
            CMD_REMOVE: begin
              ctrl.op = CELL_MATCH;
              state_d = S_REMOVE;
            end
            CMD_CLEAR: begin
              ctrl.op = CELL_CLEAR;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_REMOVE: begin
        state_d = S_REPORT;
        if (q_empty) begin
          status_d = ST_EMPTY;
        end else if (!(|cell_match)) begin
          status_d = ST_NOT_FOUND;
        end else begin
          ctrl.op = CELL_REMOVE;
          count_d = count_q - CountW'(1);
        end
      end
      S_REPORT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_d  = OutDataW'({tail_sel, head_sel, count_q, status_q, popped_q});
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q   <= popped_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tvalid_o = out_valid_q;

  `DQVR_ASSERT(a_valid_packed, (cell_valid & (cell_valid + DEPTH'(1))) == '0)
  `DQVR_ASSERT(a_count_matches, count_q == CountW'($countones(cell_valid)))
  `DQVR_ASSERT_NEVER(a_count_bound, count_q > CountW'(DEPTH))
  `DQVR_ASSERT(a_remove_entry, (state_q == S_REMOVE) |-> $past(in_fire))
  `DQVR_ASSERT(a_result_source, $rose(m_axis_tvalid_o) |-> $past(state_q == S_REPORT))

endmodule
